/* src/csl_pkg.sv */
`default_nettype none

package csl_pkg;

  localparam int COUNTER_WIDTH_DEF = 16;

  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_IDENT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SLASH = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LINE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STAR  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DONE  = 3'd6;

  localparam logic [3:0] KIND_STRUCT  = 4'd0;
  localparam logic [3:0] KIND_TYPEDEF = 4'd1;
  localparam logic [3:0] KIND_REFLECT = 4'd2;
  localparam logic [3:0] KIND_IDENT   = 4'd3;
  localparam logic [3:0] KIND_LBRACE  = 4'd4;
  localparam logic [3:0] KIND_RBRACE  = 4'd5;
  localparam logic [3:0] KIND_LPAREN  = 4'd6;
  localparam logic [3:0] KIND_RPAREN  = 4'd7;
  localparam logic [3:0] KIND_SEMI    = 4'd8;
  localparam logic [3:0] KIND_END     = 4'd9;
  localparam logic [3:0] KIND_INVALID = 4'd10;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

/* src/csl_if.sv */
`default_nettype none

interface csl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       byte_present;
  logic       end_of_source;

  modport source (output valid, output source_byte, output byte_present,
                  output end_of_source, input ready);
  modport sink (input valid, input source_byte, input byte_present,
                input end_of_source, output ready);
endinterface

interface csl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] tok_line;
  logic [15:0] tok_col;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output tok_line,
                  output tok_col, output token_length, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input tok_line,
                input tok_col, input token_length, input last_of_run,
                output ready);
endinterface

`default_nettype wire

/* src/c_subset_lexer.sv */
// Streaming lexer for a small C subset.
// src_i carries one word per source byte (source_byte, byte_present,
// end_of_source); tok_o carries one word per token (kind, start line,
// start column, length, last_of_run).
// Each accepted word is scanned in the cycle it is accepted; its tokens,
// zero to three, are written into a four-entry result queue whose
// registered head drives tok_o, one token per cycle unless tok_o stalls.
// Throughput: one source word per cycle while each word yields at most one
// token and tok_o is not stalled. src_i.ready is high whenever the queue,
// after this cycle's pop, holds at most one token, so a word that closes
// several tokens at once holds the input until the queue drains back to
// at most one token.
// A stall on tok_o holds the head token; the input keeps flowing until the
// queue holds two tokens.
// Reset empties the queue and sets line and column to 1 with no open token.
// A word with end_of_source returns the scanner to that same state after its
// tokens are queued.

`default_nettype none

module c_subset_lexer #(
  parameter int COUNTER_WIDTH = csl_pkg::COUNTER_WIDTH_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  csl_in_if.sink    src_i,
  csl_out_if.source tok_o
);
  import csl_pkg::*;

  localparam int W = COUNTER_WIDTH;
  localparam int QDEPTH = 4;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [W-1:0]      line_q, line_d, col_q, col_d;
  logic [W-1:0]      tsl_q, tsl_d, tsc_q, tsc_d, ilen_q, ilen_d;
  logic [2:0]        cand_q, cand_d;

  result_t    res [MAX_RES];
  logic [1:0] res_cnt;

  result_t    q_q [QDEPTH];
  result_t    q_d [QDEPTH];
  logic [2:0] cnt_q, cnt_d, base_cnt;
  logic       accept, pop;

  csl_step #(.W(W)) u_step (
    .byte_i    (src_i.source_byte),
    .present_i (src_i.byte_present),
    .last_i    (src_i.end_of_source),
    .mode_i    (mode_q),
    .line_i    (line_q),
    .col_i     (col_q),
    .tsl_i     (tsl_q),
    .tsc_i     (tsc_q),
    .ilen_i    (ilen_q),
    .cand_i    (cand_q),
    .mode_o    (mode_d),
    .line_o    (line_d),
    .col_o     (col_d),
    .tsl_o     (tsl_d),
    .tsc_o     (tsc_d),
    .ilen_o    (ilen_d),
    .cand_o    (cand_d),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  assign pop         = tok_o.valid && tok_o.ready;
  assign base_cnt    = cnt_q - 3'(pop);
  assign src_i.ready = (base_cnt <= 3'd1);
  assign accept      = src_i.valid && src_i.ready;
  assign cnt_d       = base_cnt + (accept ? {1'b0, res_cnt} : 3'd0);

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) q_d[i] = q_q[i];
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) q_d[i] = q_q[i + 1];
    end
    if (accept) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < res_cnt) q_d[base_cnt[1:0] + 2'(i)] = res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= W'(1);
      col_q  <= W'(1);
      tsl_q  <= '0;
      tsc_q  <= '0;
      ilen_q <= '0;
      cand_q <= 3'b111;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        mode_q <= mode_d;
        line_q <= line_d;
        col_q  <= col_d;
        tsl_q  <= tsl_d;
        tsc_q  <= tsc_d;
        ilen_q <= ilen_d;
        cand_q <= cand_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) q_q[i] <= q_d[i];
  end

  assign tok_o.valid        = (cnt_q != 3'd0);
  assign tok_o.token_kind   = q_q[0].kind;
  assign tok_o.tok_line     = q_q[0].line;
  assign tok_o.tok_col      = q_q[0].col;
  assign tok_o.token_length = q_q[0].len;
  assign tok_o.last_of_run  = q_q[0].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_o.valid && tok_o.token_kind == KIND_END |-> tok_o.last_of_run)
    else $error("end token not marked last");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && src_i.end_of_source |=>
      mode_q == MODE_IDLE && line_q == W'(1) && col_q == W'(1))
    else $error("scanner not restarted after end of source");

endmodule

`default_nettype wire

/* src/csl_step.sv */
`default_nettype none

module csl_step #(
  parameter int W = 16
) (
  input  wire logic [7:0]                  byte_i,
  input  wire logic                        present_i,
  input  wire logic                        last_i,
  input  wire logic [csl_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [W-1:0]                line_i,
  input  wire logic [W-1:0]                col_i,
  input  wire logic [W-1:0]                tsl_i,
  input  wire logic [W-1:0]                tsc_i,
  input  wire logic [W-1:0]                ilen_i,
  input  wire logic [2:0]                  cand_i,
  output logic      [csl_pkg::MODE_W-1:0]  mode_o,
  output logic      [W-1:0]                line_o,
  output logic      [W-1:0]                col_o,
  output logic      [W-1:0]                tsl_o,
  output logic      [W-1:0]                tsc_o,
  output logic      [W-1:0]                ilen_o,
  output logic      [2:0]                  cand_o,
  output csl_pkg::result_t                 res_o [csl_pkg::MAX_RES],
  output logic      [1:0]                  res_cnt_o
);
  import csl_pkg::*;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3b;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f};
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0b, 8'h0c};
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] n;
    case (k)
      2'd0:    n = 4'd6;
      2'd1:    n = 4'd7;
      2'd2:    n = 4'd10;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          4'd0:    ch = 8'h73;
          4'd1:    ch = 8'h74;
          4'd2:    ch = 8'h72;
          4'd3:    ch = 8'h75;
          4'd4:    ch = 8'h63;
          4'd5:    ch = 8'h74;
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          4'd0:    ch = 8'h74;
          4'd1:    ch = 8'h79;
          4'd2:    ch = 8'h70;
          4'd3:    ch = 8'h65;
          4'd4:    ch = 8'h64;
          4'd5:    ch = 8'h65;
          4'd6:    ch = 8'h66;
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          4'd0:    ch = 8'h48;
          4'd1:    ch = 8'h4d;
          4'd2:    ch = 8'h5f;
          4'd3:    ch = 8'h52;
          4'd4:    ch = 8'h45;
          4'd5:    ch = 8'h46;
          4'd6:    ch = 8'h4c;
          4'd7:    ch = 8'h45;
          4'd8:    ch = 8'h43;
          4'd9:    ch = 8'h54;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] filter(input logic [2:0] cand, input logic [W-1:0] idx,
                                        input logic [7:0] c);
    logic [2:0] f;
    f = cand;
    for (int k = 0; k < 3; k++) begin
      if (idx >= W'(kw_len(2'(k))) || kw_char(2'(k), idx[3:0]) != c) begin
        f[k] = 1'b0;
      end
    end
    return f;
  endfunction

  function automatic logic [15:0] clip(input logic [W-1:0] v);
    return (v > W'(16'hffff)) ? 16'hffff : 16'(v);
  endfunction

  function automatic result_t mk(input logic [3:0] kind, input logic [W-1:0] ln,
                                 input logic [W-1:0] cl, input logic [W-1:0] len);
    result_t r;
    r.kind = kind;
    r.line = clip(ln);
    r.col  = clip(cl);
    r.len  = clip(len);
    r.last = 1'b0;
    return r;
  endfunction

  always_comb begin : step_blk
    logic [MODE_W-1:0] m;
    logic [W-1:0]      ln, cl, sl, sc, il;
    logic [2:0]        cd;
    logic [1:0]        n;
    logic              go_idle;
    logic              adv;
    logic [3:0]        kind;
    result_t           r [MAX_RES];

    m = mode_i;
    ln = line_i;
    cl = col_i;
    sl = tsl_i;
    sc = tsc_i;
    il = ilen_i;
    cd = cand_i;
    n = 2'd0;
    go_idle = 1'b0;
    adv = 1'b0;
    kind = KIND_IDENT;
    for (int i = 0; i < MAX_RES; i++) r[i] = '0;

    if (m == MODE_DONE) begin
      if (last_i) begin
        m = MODE_IDLE;
        ln = W'(1);
        cl = W'(1);
        sl = '0;
        sc = '0;
        il = '0;
        cd = 3'b111;
      end
    end else begin
      // consume one byte
      if (present_i && byte_i != CH_NUL) begin
        case (m)
          MODE_IDENT: begin
            if (is_alnum(byte_i)) begin
              cd = filter(cd, il, byte_i);
              if (il != {W{1'b1}}) il = il + W'(1);
              adv = 1'b1;
            end else begin
              kind = KIND_IDENT;
              if (cd[0] && il == W'(kw_len(2'd0))) kind = KIND_STRUCT;
              else if (cd[1] && il == W'(kw_len(2'd1))) kind = KIND_TYPEDEF;
              else if (cd[2] && il == W'(kw_len(2'd2))) kind = KIND_REFLECT;
              r[n] = mk(kind, sl, sc, il);
              n = n + 2'd1;
              go_idle = 1'b1;
            end
          end
          MODE_SLASH: begin
            if (byte_i == CH_SLASH || byte_i == CH_STAR) begin
              m = (byte_i == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
              adv = 1'b1;
            end else begin
              r[n] = mk(KIND_INVALID, sl, sc, W'(1));
              n = n + 2'd1;
              go_idle = 1'b1;
            end
          end
          MODE_LINE: begin
            if (byte_i == CH_NL) m = MODE_IDLE;
            adv = 1'b1;
          end
          MODE_BLOCK, MODE_STAR: begin
            if (byte_i == CH_STAR) m = MODE_STAR;
            else if (byte_i == CH_SLASH && m == MODE_STAR) m = MODE_IDLE;
            else m = MODE_BLOCK;
            adv = 1'b1;
          end
          default: go_idle = 1'b1;
        endcase

        if (go_idle) begin
          m = MODE_IDLE;
          adv = 1'b1;
          if (!is_space(byte_i)) begin
            sl = ln;
            sc = cl;
            if (is_alpha(byte_i)) begin
              m = MODE_IDENT;
              il = W'(1);
              cd = filter(3'b111, '0, byte_i);
            end else if (byte_i == CH_SLASH) begin
              m = MODE_SLASH;
            end else begin
              case (byte_i)
                CH_LBRACE: kind = KIND_LBRACE;
                CH_RBRACE: kind = KIND_RBRACE;
                CH_LPAREN: kind = KIND_LPAREN;
                CH_RPAREN: kind = KIND_RPAREN;
                CH_SEMI:   kind = KIND_SEMI;
                default:   kind = KIND_INVALID;
              endcase
              r[n] = mk(kind, ln, cl, W'(1));
              n = n + 2'd1;
            end
          end
        end

        if (adv) begin
          if (byte_i == CH_NL) begin
            if (ln != {W{1'b1}}) ln = ln + W'(1);
            cl = W'(1);
          end else if (cl != {W{1'b1}}) begin
            cl = cl + W'(1);
          end
        end
      end

      // end of text: zero byte or end marker
      if ((present_i && byte_i == CH_NUL) || last_i) begin
        if (m == MODE_IDENT) begin
          kind = KIND_IDENT;
          if (cd[0] && il == W'(kw_len(2'd0))) kind = KIND_STRUCT;
          else if (cd[1] && il == W'(kw_len(2'd1))) kind = KIND_TYPEDEF;
          else if (cd[2] && il == W'(kw_len(2'd2))) kind = KIND_REFLECT;
          r[n] = mk(kind, sl, sc, il);
          n = n + 2'd1;
        end else if (m == MODE_SLASH) begin
          r[n] = mk(KIND_INVALID, sl, sc, W'(1));
          n = n + 2'd1;
        end
        r[n] = mk(KIND_END, ln, cl, '0);
        n = n + 2'd1;
        if (last_i) begin
          m = MODE_IDLE;
          ln = W'(1);
          cl = W'(1);
          sl = '0;
          sc = '0;
          il = '0;
          cd = 3'b111;
        end else begin
          m = MODE_DONE;
        end
      end
    end

    if (n != 2'd0) r[n - 2'd1].last = 1'b1;

    mode_o = m;
    line_o = ln;
    col_o = cl;
    tsl_o = sl;
    tsc_o = sc;
    ilen_o = il;
    cand_o = cd;
    res_cnt_o = n;
    for (int i = 0; i < MAX_RES; i++) res_o[i] = r[i];
  end

endmodule

`default_nettype wire
